@@ hw/rtl/mmd_pkg.sv @@
// Shared types and constants for the management mailbox block.
// No dependencies; imported by mmd_image and mgmt_mailbox_dpram.
package mmd_pkg;

	localparam int unsigned MBX_BYTES = 16384;
	localparam int unsigned MBX_AW    = $clog2(MBX_BYTES);

	typedef logic [MBX_AW-1:0] mbx_addr_t;
	typedef logic [7:0]        byte_t;
	typedef logic [2:0]        ncpu_t;

	// one byte of the status image: hit says whether the image owns the address
	typedef struct packed {
		logic  hit;
		byte_t data;
	} img_t;

	// command block bytes
	localparam mbx_addr_t A_LEN   = 14'h00f9;
	localparam mbx_addr_t A_QLO   = 14'h00fa;
	localparam mbx_addr_t A_QHI   = 14'h00fb;
	localparam mbx_addr_t A_STAT  = 14'h00fc;
	localparam mbx_addr_t A_MIRR  = 14'h00fd;
	localparam mbx_addr_t A_OPC   = 14'h00fe;
	localparam mbx_addr_t A_CMD   = 14'h00ff;
	localparam mbx_addr_t A_FRU_SRC = 14'h3500;

	// processor start slots
	localparam mbx_addr_t A_START1 = 14'h3428;
	localparam mbx_addr_t A_START2 = 14'h3438;
	localparam mbx_addr_t A_START3 = 14'h3448;

	// opcodes
	localparam byte_t OP_NOP      = 8'h00;
	localparam byte_t OP_FRU_WR   = 8'h01;
	localparam byte_t OP_NOP2     = 8'h02;
	localparam byte_t OP_REFRESH  = 8'h03;
	localparam byte_t OP_NOP_F0   = 8'hf0;

	// status codes
	localparam byte_t STS_OK      = 8'h00;
	localparam byte_t STS_BAD_IDX = 8'h80;
	localparam byte_t STS_BAD_OP  = 8'h81;

	// configuration register indexes
	localparam logic [1:0] CFG_CPU_COUNT = 2'd0;
	localparam logic [1:0] CFG_CLK_MHZ   = 2'd1;
	localparam logic [1:0] CFG_STAMP     = 2'd2;

endpackage

@@ hw/rtl/mmd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mmd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/mmd_image.sv @@
// Status image lookup: for one mailbox address, whether the reset image owns
// the byte and its value. Depends on mmd_pkg.
module mmd_image (
	input  mmd_pkg::mbx_addr_t addr,
	input  mmd_pkg::ncpu_t     ncpu,
	input  logic [15:0]        clk_mhz,
	input  logic [47:0]        stamp,
	output mmd_pkg::img_t      img
);
	import mmd_pkg::*;

	localparam byte_t HEAD_IMG [11] = '{
		8'h01, 8'h80, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'hdd, 8'h01, 8'hff
	};
	// three supply records of nine bytes, first byte numbered per supply
	localparam byte_t PSU_IMG [27] = '{
		8'hf4, 8'h45, 8'h51, 8'h37, 8'h8b, 8'h6b, 8'h49, 8'h4b, 8'h00,
		8'hf5, 8'h45, 8'h51, 8'h37, 8'h8b, 8'h6b, 8'h49, 8'h4b, 8'h00,
		8'hf6, 8'h45, 8'h51, 8'h37, 8'h8b, 8'h6b, 8'h49, 8'h4b, 8'h00
	};
	localparam byte_t I2C_IMG [4] = '{8'h0e, 8'h0c, 8'h08, 8'h00};
	// firmware version strings at 0x3000 and 0x3009
	localparam byte_t ROM_IMG [16] = '{
		8'h56, 8'h32, 8'h2e, 8'h32, 8'h32, 8'h47, 8'h00, 8'h00,
		8'h00, 8'h56, 8'h31, 8'h30, 8'h56, 8'h31, 8'h30, 8'h00
	};
	localparam logic [15:0] ROM_HIT = 16'h7e7f;

	byte_t      off;
	logic [1:0] cpu_slot;
	logic [2:0] start_slot;
	logic [4:0] psu_idx;
	logic [1:0] i2c_idx;

	assign off        = addr[7:0];
	assign cpu_slot   = 2'(off - 8'h93);
	assign start_slot = addr[6:4] - 3'd1;
	assign psu_idx    = 5'(off - 8'hdb);
	assign i2c_idx    = 2'(ncpu - 3'd1);

	always_comb begin
		img = '0;
		if (addr[13:8] == 6'h00) begin
			priority if (off <= 8'h0a) begin
				img.hit = 1'b1; img.data = HEAD_IMG[off[3:0]];
			end else if (off == 8'h0b) begin
				img.hit = 1'b1; img.data = clk_mhz[7:0];
			end else if (off == 8'h0c) begin
				img.hit = 1'b1; img.data = clk_mhz[15:8];
			end else if (off >= 8'h10 && off <= 8'h15) begin
				img.hit = 1'b1;
				unique case (off[2:0])
					3'd0: img.data = stamp[7:0];
					3'd1: img.data = stamp[15:8];
					3'd2: img.data = stamp[23:16];
					3'd3: img.data = stamp[31:24];
					3'd4: img.data = stamp[39:32];
					3'd5: img.data = stamp[47:40];
					default: img.data = '0;
				endcase
			end else if (off == 8'h16) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'h1e) begin
				img.hit = 1'b1; img.data = 8'h80;
			end else if (off == 8'h1f) begin
				img.hit = 1'b1; img.data = 8'h08;
			end else if (off == 8'h90) begin
				img.hit = 1'b1; img.data = 8'hff;
			end else if (off == 8'h91) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'h92) begin
				img.hit = 1'b1; img.data = 8'h07;
			end else if (off >= 8'h93 && off <= 8'h96) begin
				// one presence byte per processor, absent ones keep their contents
				img.hit  = ({1'b0, cpu_slot} < ncpu);
				img.data = 8'h40;
			end else if (off >= 8'h97 && off <= 8'h99) begin
				img.hit = 1'b1; img.data = 8'h40;
			end else if (off >= 8'h9a && off <= 8'h9f) begin
				img.hit = 1'b1; img.data = 8'h8b;
			end else if (off == 8'haf) begin
				img.hit = 1'b1; img.data = I2C_IMG[i2c_idx];
			end else if (off >= 8'ha0 && off <= 8'hb2) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'hba) begin
				img.hit = 1'b1; img.data = 8'hba;
			end else if (off == 8'hbd) begin
				img.hit = 1'b1; img.data = 8'h07;
			end else if (off >= 8'hbb && off <= 8'hbf) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'hd9) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'hda) begin
				img.hit = 1'b1; img.data = 8'haa;
			end else if (off >= 8'hdb && off <= 8'hf5) begin
				img.hit = 1'b1; img.data = PSU_IMG[psu_idx];
			end else if (off >= 8'hf9 && off <= 8'hfc) begin
				img.hit = 1'b1; img.data = 8'h00;
			end else if (off == 8'hfd || off == 8'hff) begin
				img.hit = 1'b1; img.data = 8'h01;
			end else begin
				img.hit = 1'b0;
			end
		end else if (addr >= 14'h2900 && addr <= 14'h2dff) begin
			img.hit = 1'b1; img.data = 8'h00;
		end else if (addr[13:4] == 10'h300) begin
			img.hit  = ROM_HIT[addr[3:0]];
			img.data = ROM_IMG[addr[3:0]];
		end else if (addr == 14'h3400 || addr == 14'h3401) begin
			img.hit = 1'b1; img.data = 8'h08;
		end else if (addr == 14'h3402) begin
			img.hit = 1'b1; img.data = 8'h00;
		end else if (addr[13:8] == 6'h34 && addr[3:0] == 4'h8 &&
			addr[7:4] >= 4'h1 && addr[7:4] <= 4'h4) begin
			// start slot marker for each present processor
			img.hit  = (start_slot < ncpu);
			img.data = 8'hff;
		end else if (addr[13:5] == 9'h1a5) begin
			img.hit = 1'b1; img.data = {3'b000, addr[4:0]};
		end
	end

endmodule

@@ hw/rtl/mgmt_mailbox_dpram.sv @@
// Management mailbox top level: bus access sequencer around a 16 KiB mailbox RAM.
// Depends on mmd_pkg, mmd_ram and mmd_image.
//
//  channel | ports                          | direction | payload
//  s       | s_tvalid s_tready s_tdata s_tuser | in     | one bus access
//  m       | m_tvalid m_tready m_tdata m_tuser | out    | one result per access
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in | register write
//
// Every access goes through the single RAM port pair: reads, plain writes, writes
// to 0xfd, start requests and commands, which copy each FRU byte by a read and a write.
// After reset the sequencer clears all 16384 bytes and writes the status image, then
// copies the per-processor blocks; a write to a defined register reruns the pass
// without the clear. s_tready and cfg_ready stay low during the pass and while an
// access runs. A stalled m channel holds the finished result in a holding state.
module mgmt_mailbox_dpram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[13:0], write_data[21:14], zero[23:22]
	input  logic [0:0]  s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // read_data[7:0], cpu_start_index[9:8],
	                               // cpu_start_entry[73:10], display_refresh[74], zero[79:75]
	output logic [0:0]  m_tuser,   // cpu_start_valid[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	import mmd_pkg::*;

	typedef enum logic [3:0] {
		S_FILL, S_CPY_RD, S_CPY_WR, S_IDLE, S_READ, S_MIRROR, S_CMD, S_EVAL,
		S_FRU_RD, S_FRU_WR, S_STATUS, S_ENTRY, S_HOLD
	} state_t;

	typedef struct packed {
		logic        refresh;
		logic [63:0] entry;
		logic [1:0]  idx;
		logic        valid;
		byte_t       rd;
	} res_t;

	state_t      state_q;
	logic        clear_q;
	mbx_addr_t   sweep_q;
	logic [1:0]  cpy_cpu_q;
	logic [4:0]  cpy_off_q;
	ncpu_t       cpu_count_q;
	logic [15:0] clk_mhz_q;
	logic [47:0] stamp_q;
	mbx_addr_t   addr_q;
	byte_t       data_q;
	logic [3:0]  step_q;
	byte_t       op_q;
	byte_t       len_q;
	byte_t       hi_q;
	byte_t       lo_q;
	byte_t       status_q;
	logic        refresh_q;
	mbx_addr_t   src_q;
	mbx_addr_t   dst_q;
	byte_t       cnt_q;
	logic [63:0] entry_q;
	logic [1:0]  start_idx_q;
	res_t        res_q;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic [0:0]  m_tuser_q;

	ncpu_t       ncpu;
	img_t        img;
	logic        ram_we;
	mbx_addr_t   ram_waddr;
	byte_t       ram_wdata;
	mbx_addr_t   ram_raddr;
	byte_t       ram_rdata;
	logic        in_wr;
	mbx_addr_t   in_addr;
	byte_t       in_data;
	logic        in_fire;
	logic        in_mirror;
	logic        in_start;
	logic [1:0]  start_k;
	logic        start_ok;
	logic        fru_ok;
	byte_t       eval_sts;
	logic        out_free;
	logic        fin;
	res_t        res_d;
	mbx_addr_t   cmd_addr;

	assign in_wr   = s_tuser[0];
	assign in_addr = s_tdata[13:0];
	assign in_data = s_tdata[21:14];

	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// processor count clamped to 1..4
	always_comb begin
		if (cpu_count_q == 3'd0) begin
			ncpu = 3'd1;
		end else if (cpu_count_q > 3'd4) begin
			ncpu = 3'd4;
		end else begin
			ncpu = cpu_count_q;
		end
	end

	assign in_mirror = (in_addr == A_CMD) || (in_addr == A_MIRR);
	assign in_start  = (in_addr == A_START1) || (in_addr == A_START2) || (in_addr == A_START3);
	assign start_k   = 2'(in_addr[6:4] - 3'd1);
	assign start_ok  = ({1'b0, start_k} < ncpu);

	always_comb begin
		if (hi_q >= 8'h21 && hi_q <= 8'h24) begin
			fru_ok = (hi_q - 8'h20) <= {5'b00000, ncpu};
		end else begin
			fru_ok = (hi_q >= 8'h01 && hi_q <= 8'h2a) || (hi_q >= 8'h31 && hi_q <= 8'h33) ||
				(hi_q >= 8'h3b && hi_q <= 8'h3f);
		end
	end

	// command status from the latched opcode
	always_comb begin
		unique case (op_q)
			OP_FRU_WR: eval_sts = fru_ok ? STS_OK : STS_BAD_IDX;
			OP_NOP, OP_NOP2, OP_REFRESH, OP_NOP_F0: eval_sts = STS_OK;
			default: eval_sts = STS_BAD_OP;
		endcase
	end

	always_comb begin
		unique case (step_q[1:0])
			2'd0: cmd_addr = A_OPC;
			2'd1: cmd_addr = A_LEN;
			2'd2: cmd_addr = A_QHI;
			2'd3: cmd_addr = A_QLO;
			default: cmd_addr = A_OPC;
		endcase
	end

	mmd_image u_image (
		.addr    (sweep_q),
		.ncpu    (ncpu),
		.clk_mhz (clk_mhz_q),
		.stamp   (stamp_q),
		.img     (img)
	);

	mmd_ram #(
		.WIDTH (8),
		.DEPTH (MBX_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = data_q;
		ram_raddr = addr_q;
		unique case (state_q)
			S_FILL: begin
				ram_we    = clear_q || img.hit;
				ram_waddr = sweep_q;
				ram_wdata = img.hit ? img.data : 8'h00;
			end
			S_CPY_RD: ram_raddr = {9'b0, cpy_off_q};
			S_CPY_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {7'b0, cpy_cpu_q, cpy_off_q};
				ram_wdata = ram_rdata;
			end
			S_IDLE: begin
				ram_raddr = in_addr;
				ram_we    = in_fire && in_wr;
				ram_waddr = in_addr;
				ram_wdata = in_data;
			end
			S_MIRROR: begin
				ram_we    = 1'b1;
				ram_waddr = (addr_q == A_CMD) ? A_MIRR : A_CMD;
			end
			S_CMD:    ram_raddr = cmd_addr;
			S_FRU_RD: ram_raddr = src_q;
			S_FRU_WR: begin
				ram_we    = 1'b1;
				ram_waddr = dst_q;
				ram_wdata = ram_rdata;
			end
			S_STATUS: begin
				ram_we    = 1'b1;
				ram_waddr = A_STAT;
				ram_wdata = status_q;
			end
			S_ENTRY: ram_raddr = {addr_q[13:4], 1'b0, step_q[2:0]};
			default: ;
		endcase
	end

	// result of the current access, when it finishes this cycle
	always_comb begin
		fin   = 1'b0;
		res_d = '0;
		unique case (state_q)
			S_IDLE:   fin = in_fire && in_wr && !in_mirror && !(in_start && start_ok);
			S_READ: begin
				fin      = 1'b1;
				res_d.rd = ram_rdata;
			end
			S_MIRROR: fin = (addr_q == A_MIRR);
			S_ENTRY: begin
				if (step_q == 4'd8) begin
					fin         = 1'b1;
					res_d.valid = 1'b1;
					res_d.idx   = start_idx_q;
					res_d.entry = {ram_rdata, entry_q[63:8]};
				end
			end
			S_STATUS: begin
				fin           = 1'b1;
				res_d.refresh = refresh_q;
			end
			S_HOLD: begin
				fin   = 1'b1;
				res_d = res_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			clear_q     <= 1'b1;
			sweep_q     <= '0;
			cpy_cpu_q   <= 2'd1;
			cpy_off_q   <= '0;
			cpu_count_q <= 3'd1;
			clk_mhz_q   <= 16'd500;
			stamp_q     <= '0;
			addr_q      <= '0;
			data_q      <= '0;
			step_q      <= '0;
			op_q        <= '0;
			len_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			status_q    <= '0;
			refresh_q   <= 1'b0;
			src_q       <= '0;
			dst_q       <= '0;
			cnt_q       <= '0;
			entry_q     <= '0;
			start_idx_q <= '0;
			res_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			unique case (state_q)
				S_FILL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						clear_q   <= 1'b0;
						cpy_cpu_q <= 2'd1;
						cpy_off_q <= '0;
						state_q   <= (ncpu == 3'd1) ? S_IDLE : S_CPY_RD;
					end
				end
				S_CPY_RD: state_q <= S_CPY_WR;
				S_CPY_WR: begin
					// copy bytes 0x00..0x1e into each further processor block
					if (cpy_off_q == 5'h1e) begin
						cpy_off_q <= '0;
						if ({1'b0, cpy_cpu_q} + 3'd1 == ncpu) begin
							state_q <= S_IDLE;
						end else begin
							cpy_cpu_q <= cpy_cpu_q + 1'b1;
							state_q   <= S_CPY_RD;
						end
					end else begin
						cpy_off_q <= cpy_off_q + 1'b1;
						state_q   <= S_CPY_RD;
					end
				end
				S_IDLE: begin
					if (cfg_valid) begin
						sweep_q <= '0;
						unique case (cfg_index)
							CFG_CPU_COUNT: begin
								cpu_count_q <= cfg_data[2:0];
								state_q     <= S_FILL;
							end
							CFG_CLK_MHZ: begin
								clk_mhz_q <= cfg_data[15:0];
								state_q   <= S_FILL;
							end
							CFG_STAMP: begin
								stamp_q <= cfg_data;
								state_q <= S_FILL;
							end
							default: ;
						endcase
					end else if (in_fire) begin
						addr_q      <= in_addr;
						data_q      <= in_data;
						step_q      <= '0;
						start_idx_q <= start_k;
						if (!in_wr) begin
							state_q <= S_READ;
						end else if (in_mirror) begin
							state_q <= S_MIRROR;
						end else if (in_start && start_ok) begin
							state_q <= S_ENTRY;
						end
					end
				end
				S_READ: ;
				S_MIRROR: begin
					if (addr_q == A_CMD) begin
						step_q    <= '0;
						refresh_q <= 1'b0;
						state_q   <= S_CMD;
					end
				end
				S_CMD: begin
					step_q <= step_q + 1'b1;
					unique case (step_q)
						4'd1: op_q  <= ram_rdata;
						4'd2: len_q <= ram_rdata + 8'd1;
						4'd3: hi_q  <= ram_rdata;
						4'd4: begin
							lo_q    <= ram_rdata;
							state_q <= S_EVAL;
						end
						default: ;
					endcase
				end
				S_EVAL: begin
					status_q  <= eval_sts;
					refresh_q <= (op_q == OP_REFRESH);
					if (op_q == OP_FRU_WR && fru_ok && len_q != 8'd0) begin
						src_q   <= A_FRU_SRC + {6'b0, lo_q};
						dst_q   <= {hi_q[5:0], lo_q};
						cnt_q   <= '0;
						state_q <= S_FRU_RD;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_FRU_RD: state_q <= S_FRU_WR;
				S_FRU_WR: begin
					src_q <= src_q + 1'b1;
					dst_q <= dst_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == len_q - 8'd1) ? S_STATUS : S_FRU_RD;
				end
				S_STATUS: ;
				S_ENTRY: begin
					step_q <= step_q + 1'b1;
					// shift bytes in from the top: lowest address ends in bits 7:0
					if (step_q != 4'd0) begin
						entry_q <= {ram_rdata, entry_q[63:8]};
					end
				end
				S_HOLD: ;
				default: state_q <= S_IDLE;
			endcase

			if (fin) begin
				res_q   <= res_d;
				state_q <= out_free ? S_IDLE : S_HOLD;
			end

			if (fin && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'b00000, res_d.refresh, res_d.entry, res_d.idx, res_d.rd};
				m_tuser_q  <= res_d.valid;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
